>>> sv/nspn_pkg.sv
// ----------------------------------------------------------------------------
// nspn_pkg
// Shared types, tables and nibble functions of the 64-bit nibble SPN cipher.
// ----------------------------------------------------------------------------
package nspn_pkg;

  localparam int BLOCK_W      = 64;
  localparam int NIBBLES      = 16;
  localparam int RC_ENTRIES   = 33;
  localparam int RC_IDX_W     = 6;
  localparam int ROUNDS_W     = 6;
  localparam int CFG_IDX_W    = 2;
  localparam int MAX_ROUNDS_D = 32;
  localparam int ROUNDS_RESET = 32;

  typedef logic [3:0]         nib_t;
  typedef logic [BLOCK_W-1:0] blk_t;
  typedef nib_t               nibs_t [NIBBLES];

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FIRST_KEY   = 2'd0,
    REG_SECOND_KEY  = 2'd1,
    REG_ROUND_COUNT = 2'd2,
    REG_UNUSED      = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    blk_t                k0;
    blk_t                k1;
    logic [ROUNDS_W-1:0] rounds;   // already clamped to the pipeline depth
  } key_cfg_t;

  localparam nib_t SBOX [16] = '{
    4'hc, 4'ha, 4'hd, 4'h3, 4'he, 4'hb, 4'hf, 4'h7,
    4'h9, 4'h8, 4'h1, 4'h5, 4'h0, 4'h2, 4'h4, 4'h6
  };

  localparam nib_t ROW_MAT [16] = '{
    4'd1, 4'd4, 4'd9, 4'd13,  4'd4, 4'd1, 4'd13, 4'd9,
    4'd9, 4'd13, 4'd1, 4'd4,  4'd13, 4'd9, 4'd4, 4'd1
  };

  localparam nib_t COL_MAT [16] = '{
    4'd13, 4'd9, 4'd4, 4'd1,  4'd9, 4'd13, 4'd1, 4'd4,
    4'd4, 4'd1, 4'd13, 4'd9,  4'd1, 4'd4, 4'd9, 4'd13
  };

  localparam nib_t RC_EVEN [RC_ENTRIES] = '{
    4'h0, 4'h0, 4'h0, 4'h1, 4'h3, 4'h7, 4'h7, 4'h7, 4'h6, 4'h5, 4'h3,
    4'h7, 4'h7, 4'h6, 4'h4, 4'h1, 4'h3, 4'h7, 4'h6, 4'h5, 4'h2, 4'h5,
    4'h3, 4'h6, 4'h4, 4'h0, 4'h0, 4'h1, 4'h2, 4'h5, 4'h3, 4'h7, 4'h6
  };

  localparam nib_t RC_ODD [RC_ENTRIES] = '{
    4'h1, 4'h3, 4'h7, 4'h7, 4'h7, 4'h6, 4'h5, 4'h3, 4'h7, 4'h7, 4'h6,
    4'h4, 4'h1, 4'h3, 4'h7, 4'h6, 4'h5, 4'h2, 4'h5, 4'h3, 4'h6, 4'h4,
    4'h0, 4'h0, 4'h1, 4'h2, 4'h5, 4'h3, 4'h7, 4'h6, 4'h4, 4'h0, 4'h1
  };

  // GF(16), x^4 + x + 1
  function automatic nib_t gf_mul(nib_t x, nib_t y);
    nib_t acc;
    nib_t a;
    acc = '0;
    a   = x;
    for (int b = 0; b < 4; b++) begin
      if (y[b]) acc = acc ^ a;
      a = a[3] ? ({a[2:0], 1'b0} ^ 4'h3) : {a[2:0], 1'b0};
    end
    return acc;
  endfunction

  // nibble 0 is the most significant
  function automatic nibs_t unpack(blk_t w);
    nibs_t n;
    for (int i = 0; i < NIBBLES; i++) n[i] = w[BLOCK_W-1-4*i -: 4];
    return n;
  endfunction

  function automatic blk_t pack(nibs_t n);
    blk_t w;
    for (int i = 0; i < NIBBLES; i++) w[BLOCK_W-1-4*i -: 4] = n[i];
    return w;
  endfunction

  function automatic blk_t add_rc(blk_t w, logic [RC_IDX_W-1:0] idx);
    nibs_t n;
    n = unpack(w);
    n[9]  = n[9]  ^ 4'h1;
    n[10] = n[10] ^ 4'h2;
    n[11] = n[11] ^ 4'h4;
    n[12] = n[12] ^ RC_EVEN[idx];
    n[13] = n[13] ^ RC_ODD[idx];
    n[14] = n[14] ^ RC_EVEN[idx];
    n[15] = n[15] ^ RC_ODD[idx];
    return pack(n);
  endfunction

endpackage

>>> sv/nspn_cfg.sv
// ----------------------------------------------------------------------------
// nspn_cfg
// Key and round-count registers; the round count is clamped to the depth.
// ----------------------------------------------------------------------------
module nspn_cfg #(
  parameter int MAX_ROUNDS = nspn_pkg::MAX_ROUNDS_D
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [nspn_pkg::CFG_IDX_W-1:0] cfg_index,
  input  nspn_pkg::blk_t                 cfg_data,
  output nspn_pkg::key_cfg_t             key_cfg
);

  nspn_pkg::blk_t                k0_r, k0_nxt;
  nspn_pkg::blk_t                k1_r, k1_nxt;
  logic [nspn_pkg::ROUNDS_W-1:0] rounds_r, rounds_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    k0_nxt     = k0_r;
    k1_nxt     = k1_r;
    rounds_nxt = rounds_r;
    if (cfg_valid) begin
      case (nspn_pkg::cfg_reg_t'(cfg_index))
        nspn_pkg::REG_FIRST_KEY:   k0_nxt = cfg_data;
        nspn_pkg::REG_SECOND_KEY:  k1_nxt = cfg_data;
        nspn_pkg::REG_ROUND_COUNT: rounds_nxt = cfg_data[nspn_pkg::ROUNDS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k0_r     <= '0;
      k1_r     <= '0;
      rounds_r <= nspn_pkg::ROUNDS_W'(nspn_pkg::ROUNDS_RESET);
    end else begin
      k0_r     <= k0_nxt;
      k1_r     <= k1_nxt;
      rounds_r <= rounds_nxt;
    end
  end

  assign key_cfg.k0     = k0_r;
  assign key_cfg.k1     = k1_r;
  assign key_cfg.rounds = (rounds_r > nspn_pkg::ROUNDS_W'(MAX_ROUNDS)) ?
                          nspn_pkg::ROUNDS_W'(MAX_ROUNDS) : rounds_r;

endmodule

>>> sv/nspn_round.sv
// ----------------------------------------------------------------------------
// nspn_round
// One cipher round: S-box, row mix, column mix, S-box, key and constants.
// Passes the block through untouched when the round is not enabled.
// ----------------------------------------------------------------------------
module nspn_round (
  input  nspn_pkg::blk_t                 state_i,
  input  nspn_pkg::blk_t                 key_i,
  input  logic [nspn_pkg::RC_IDX_W-1:0]  rc_idx_i,
  input  logic                           apply_i,
  output nspn_pkg::blk_t                 state_o
);

  nspn_pkg::nibs_t s0, s1, s2, s3;
  nspn_pkg::blk_t  mixed;

  always_comb begin
    s0 = nspn_pkg::unpack(state_i);
    for (int i = 0; i < nspn_pkg::NIBBLES; i++) s1[i] = nspn_pkg::SBOX[s0[i]];
    // row mix: s * M1
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        s2[4*i+j] = '0;
        for (int k = 0; k < 4; k++)
          s2[4*i+j] = s2[4*i+j] ^ nspn_pkg::gf_mul(s1[4*i+k], nspn_pkg::ROW_MAT[4*k+j]);
      end
    end
    // column mix: M2 * s
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        s3[4*i+j] = '0;
        for (int k = 0; k < 4; k++)
          s3[4*i+j] = s3[4*i+j] ^ nspn_pkg::gf_mul(nspn_pkg::COL_MAT[4*i+k], s2[4*k+j]);
      end
    end
    for (int i = 0; i < nspn_pkg::NIBBLES; i++) s3[i] = nspn_pkg::SBOX[s3[i]];
    mixed = nspn_pkg::add_rc(nspn_pkg::pack(s3) ^ key_i, rc_idx_i);
  end

  assign state_o = apply_i ? mixed : state_i;

endmodule

>>> sv/nibble_spn_block_cipher_64_top.sv
// ----------------------------------------------------------------------------
// nibble_spn_block_cipher_64_top
// 64-bit nibble SPN block cipher, one round per pipeline stage.
// ----------------------------------------------------------------------------
// The block takes one plaintext beat per cycle while in_stall is low and
// returns its ciphertext from the last stage: one stage for whitening, then
// one stage per round, each stage a register. Stages past the configured
// round count still carry the block, unchanged, to the output. Every
// stage has its own valid bit and holds only when the stage after it is full
// and holding, so a stalled output fills the bubbles before in_stall rises.
// Configuration is taken at once (cfg_ready is always high) and must only be
// written while the pipeline is empty.
module nibble_spn_block_cipher_64_top #(
  parameter int MAX_ROUNDS = nspn_pkg::MAX_ROUNDS_D
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [63:0]                    in_plaintext,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [63:0]                    out_ciphertext,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [nspn_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                    cfg_data
);

  localparam int STAGES = MAX_ROUNDS + 1;

  nspn_pkg::key_cfg_t key_cfg;
  logic               v_r    [STAGES];
  nspn_pkg::blk_t     d_r    [STAGES];
  nspn_pkg::blk_t     d_nxt  [STAGES];
  logic               en     [STAGES];

  nspn_cfg #(.MAX_ROUNDS(MAX_ROUNDS)) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .key_cfg   (key_cfg)
  );

  // a stage moves when it is empty or the next one moves
  always_comb begin
    en[STAGES-1] = !v_r[STAGES-1] || !out_stall;
    for (int i = STAGES-2; i >= 0; i--) en[i] = !v_r[i] || en[i+1];
  end

  assign in_stall = !en[0];
  assign d_nxt[0] = nspn_pkg::add_rc(in_plaintext ^ key_cfg.k0, '0);

  for (genvar g = 1; g < STAGES; g++) begin : g_round
    // stage g holds round g-1; key alternates k1 on even rounds, k0 on odd
    nspn_round u_round (
      .state_i  (d_r[g-1]),
      .key_i    (((g - 1) % 2 == 1) ? key_cfg.k0 : key_cfg.k1),
      .rc_idx_i (nspn_pkg::RC_IDX_W'(g)),
      .apply_i  (nspn_pkg::ROUNDS_W'(g - 1) < key_cfg.rounds),
      .state_o  (d_nxt[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < STAGES; i++) v_r[i] <= 1'b0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      for (int i = 1; i < STAGES; i++) begin
        if (en[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < STAGES; i++) begin
      if (en[i]) d_r[i] <= d_nxt[i];
    end
  end

  assign out_valid      = v_r[STAGES-1];
  assign out_ciphertext = d_r[STAGES-1];

endmodule
